/* sv/lsvd_pkg.sv */
// Shared types and codes for the LIFO stack with value delete.
`timescale 1ns / 1ps

package lsvd_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  // Per-cycle control broadcast to every cell.
  typedef struct packed {
    logic shift_dn;   // push: every cell takes its upper neighbor
    logic pull_all;   // pop: every cell takes its lower neighbor
    logic pull_sel;   // delete: only the selected cell takes its lower neighbor
  } cell_ctl_t;

endpackage

/* sv/lsvd_cell.sv */
// One storage cell of the stack chain, with a local compare against the search key.
`timescale 1ns / 1ps

module lsvd_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  lsvd_pkg::cell_ctl_t                 ctl_i,
  input  logic [IW-1:0]                       idx_i,
  input  logic [lsvd_pkg::WordW-1:0]          key_i,
  input  logic [lsvd_pkg::WordW-1:0]          prev_i,
  input  logic [lsvd_pkg::WordW-1:0]          next_i,
  output logic [lsvd_pkg::WordW-1:0]          data_o,
  output logic                                hit_o
);

  logic [lsvd_pkg::WordW-1:0] data_q, data_d;
  logic                       sel;

  assign sel = (idx_i == IW'(IDX));

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_dn) begin
      data_d = prev_i;
    end else if (ctl_i.pull_all || (ctl_i.pull_sel && sel)) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = sel && (data_q == key_i);

endmodule

/* sv/lifo_stack_with_value_delete.sv */
// Push / pop / peek: result registered, valid the cycle after the input transfer; 1 per cycle
// while the result channel does not stall. Delete: the search token walks one cell per cycle
// from the top, then the cells below the hit close the gap one per cycle; input stalls until
// the walk ends, result valid the cycle after. Rate is set by that single walking token.
// Reset (async, active low) empties the stack and clears the FSM and the output valid;
// cell contents are not reset and are never read before being written.
`timescale 1ns / 1ps

module lifo_stack_with_value_delete #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           command_i,
  input  logic signed [lsvd_pkg::WordW-1:0]    value_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           status_o,
  output logic signed [lsvd_pkg::WordW-1:0]    data_out_o,
  output logic [lsvd_pkg::CountW-1:0]          entry_count_o,
  output logic                                 is_empty_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = lsvd_pkg::WordW;

  // Cell 0 is the top of stack; larger index means older entry.
  logic [WW-1:0]        cell_data [DEPTH];
  logic [DEPTH-1:0]     cell_hit;
  lsvd_pkg::cell_ctl_t  ctl;

  lsvd_pkg::state_e     state_q, state_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        count_q, count_d;
  logic [WW-1:0]        key_q;

  // output register
  logic                 out_valid_q, out_valid_d;
  lsvd_pkg::status_e    res_status_q, res_status_d;
  logic [WW-1:0]        res_data_q, res_data_d;
  logic [CW-1:0]        res_count_q;

  logic                 out_free;
  logic                 in_xfer;
  logic                 load_out;
  logic                 is_full;
  logic                 is_none;
  logic                 at_last;
  logic                 any_hit;

  // ---------------------------------------------------------------------------
  // Cell chain: each cell hands its word up or down to its neighbor.
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WW-1:0] prev_w;
    logic [WW-1:0] next_w;

    if (k == 0) begin : g_top
      assign prev_w = value_i;
    end else begin : g_mid
      assign prev_w = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_bot
      assign next_w = '0;
    end else begin : g_low
      assign next_w = cell_data[k+1];
    end

    lsvd_cell #(
      .IW  (IW),
      .IDX (k)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .idx_i  (idx_q),
      .key_i  (key_q),
      .prev_i (prev_w),
      .next_i (next_w),
      .data_o (cell_data[k]),
      .hit_o  (cell_hit[k])
    );
  end

  assign any_hit = |cell_hit;
  assign is_full = (count_q == CW'(DEPTH));
  assign is_none = (count_q == '0);
  assign at_last = ((CW'(idx_q) + CW'(1)) == count_q);

  // Sequential: a new transfer only from idle, and only if the result slot frees up.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == lsvd_pkg::S_IDLE) && out_free);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    count_d      = count_q;
    ctl          = '0;
    load_out     = 1'b0;
    res_status_d = lsvd_pkg::STAT_OK;
    res_data_d   = '0;
    out_valid_d  = out_valid_q && out_stall_i;

    case (state_q)
      lsvd_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (lsvd_pkg::cmd_e'(command_i))
            lsvd_pkg::CMD_PUSH: begin
              load_out = 1'b1;
              if (is_full) begin
                res_status_d = lsvd_pkg::STAT_FULL;
              end else begin
                ctl.shift_dn = 1'b1;
                count_d      = count_q + CW'(1);
              end
            end
            lsvd_pkg::CMD_POP,
            lsvd_pkg::CMD_PEEK: begin
              load_out = 1'b1;
              if (is_none) begin
                res_status_d = lsvd_pkg::STAT_EMPTY;
                res_data_d   = '1;
              end else begin
                res_data_d = cell_data[0];
                if (lsvd_pkg::cmd_e'(command_i) == lsvd_pkg::CMD_POP) begin
                  ctl.pull_all = 1'b1;
                  count_d      = count_q - CW'(1);
                end
              end
            end
            lsvd_pkg::CMD_DELETE: begin
              if (is_none) begin
                load_out     = 1'b1;
                res_status_d = lsvd_pkg::STAT_EMPTY;
              end else begin
                state_d = lsvd_pkg::S_SCAN;
                idx_d   = '0;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end

      lsvd_pkg::S_SCAN: begin
        // Token at idx_q; newest entries are checked first.
        if (any_hit) begin
          ctl.pull_sel = 1'b1;
          if (at_last) begin
            load_out = 1'b1;
            count_d  = count_q - CW'(1);
            state_d  = lsvd_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + IW'(1);
            state_d = lsvd_pkg::S_SHIFT;
          end
        end else if (at_last) begin
          load_out     = 1'b1;
          res_status_d = lsvd_pkg::STAT_NOTFOUND;
          state_d      = lsvd_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      lsvd_pkg::S_SHIFT: begin
        // Close the gap: one older entry moves up per cycle.
        ctl.pull_sel = 1'b1;
        if (at_last) begin
          load_out = 1'b1;
          count_d  = count_q - CW'(1);
          state_d  = lsvd_pkg::S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      default: begin
        state_d = lsvd_pkg::S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsvd_pkg::S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q <= value_i;
    end
    if (load_out) begin
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
      res_count_q  <= count_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_status_q;
  assign data_out_o    = res_data_q;
  assign entry_count_o = lsvd_pkg::CountW'(res_count_q);
  assign is_empty_o    = (res_count_q == '0);

`ifndef NO_ASSERTIONS
  // A delete in progress never overlaps a pending result.
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lsvd_pkg::S_IDLE) |-> !out_valid_q)
    else $error("result pending while delete walk is active");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // The walking token stays inside the occupied cells.
  a_token_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != lsvd_pkg::S_IDLE) |-> (CW'(idx_q) < count_q))
    else $error("delete token beyond occupied cells");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (command_i == lsvd_pkg::CMD_PUSH) && !is_full)
      |=> (count_q == CW'($past(count_q) + CW'(1))))
    else $error("accepted push did not grow the stack");

  a_walk_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != lsvd_pkg::S_IDLE) && at_last) |=> out_valid_q)
    else $error("delete walk ended without a result");
`endif

endmodule

/* tb/sv/lifo_stack_with_value_delete_test.sv */
// Self-checking testbench for the LIFO stack with value delete.
`timescale 1ns / 1ps

module lifo_stack_with_value_delete_test;
  import lsvd_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int          HoldLen   = 90;    // long receiver hold, in cycles
  localparam int          DrainWait = 40;    // covers the slowest delete walk
  localparam int          IdleLimit = 3000;  // watchdog: cycles with no transfer

  // One queued command for the driver.
  typedef struct {
    cmd_e                      op;
    logic signed [WordW-1:0]   arg;
    int                        phase;       // selects the idle mix
    bit                        wait_drain;  // hold off until every result is back
    bit                        long_hold;   // kick off a long receiver hold
  } stack_op_t;

  // One predicted result transfer.
  typedef struct {
    status_e                   status;
    logic signed [WordW-1:0]   data;
    logic [CountW-1:0]         count;
    logic                      empty;
  } stack_result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                command_i     = CMD_PUSH;
  logic signed [WordW-1:0]   value_i       = '0;
  logic                      out_valid_o;
  logic                      out_stall_i   = 1'b0;
  logic [1:0]                status_o;
  logic signed [WordW-1:0]   data_out_o;
  logic [CountW-1:0]         entry_count_o;
  logic                      is_empty_o;

  lifo_stack_with_value_delete #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .data_out_o   (data_out_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  // Commands waiting to be offered, and results waiting to be seen.
  stack_op_t      op_queue[$];
  stack_result_t  result_queue[$];
  stack_op_t      next_op;

  // Shadow copy of the stack contents.
  logic signed [WordW-1:0] shadow_cells [Depth];
  int                      shadow_fill = 0;
  int                      deepest_fill = 0;

  // Transfer bookkeeping. ops_taken is driver-local; results_seen moves by
  // nonblocking assignment so the driver always sees a settled value.
  int  ops_taken    = 0;
  int  results_seen = 0;
  int  fail_count   = 0;
  int  idle_cycles  = 0;
  int  cur_phase    = 0;
  int  hold_reqs    = 0;
  int  hold_acks    = 0;
  int  hold_left    = 0;
  int  op_tally     [4];
  int  status_tally [4];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Idle mix per phase: receiver-heavy idling, then sender-heavy, then none.
  function automatic int send_idle_pct(input int ph);
    return (ph == 0) ? 29 : (ph == 1) ? 65 : 0;
  endfunction

  function automatic int recv_idle_pct(input int ph);
    return (ph == 0) ? 65 : (ph == 1) ? 29 : 0;
  endfunction

  // Apply one accepted command to the shadow stack and queue its result.
  task automatic apply_stack_op(input cmd_e op, input logic signed [WordW-1:0] arg);
    stack_result_t r;
    int            pos;
    int            k;
    r.status = STAT_OK;
    r.data   = '0;
    case (op)
      CMD_PUSH: begin
        if (shadow_fill >= Depth) begin
          r.status = STAT_FULL;
        end else begin
          shadow_cells[shadow_fill] = arg;
          shadow_fill++;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
          r.data   = '1;
        end else begin
          r.data = shadow_cells[shadow_fill-1];
          if (op == CMD_POP) shadow_fill--;
        end
      end
      default: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          // topmost match wins; entries above it slide down one place
          for (pos = shadow_fill - 1; pos >= 0; pos--) begin
            if (shadow_cells[pos] == arg) break;
          end
          if (pos >= 0) begin
            for (k = pos; k + 1 < shadow_fill; k++) shadow_cells[k] = shadow_cells[k+1];
            shadow_fill--;
          end else begin
            r.status = STAT_NOTFOUND;
          end
        end
      end
    endcase
    r.count = shadow_fill[CountW-1:0];
    r.empty = (shadow_fill == 0);
    if (shadow_fill > deepest_fill) deepest_fill = shadow_fill;
    op_tally[op]++;
    result_queue.push_back(r);
  endtask

  // Driver: counts the transfer that completes at this edge, then loads the
  // next command only when the current one is gone or was never offered.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        apply_stack_op(cmd_e'(command_i), value_i);
        ops_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (op_queue.size() != 0 &&
            !(op_queue[0].wait_drain && ops_taken != results_seen) &&
            $urandom_range(99) >= send_idle_pct(op_queue[0].phase)) begin
          next_op = op_queue.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= next_op.op;
          value_i    <= next_op.arg;
          cur_phase  <= next_op.phase;
          if (next_op.long_hold) hold_reqs <= hold_reqs + 1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random per the phase mix, or a long hold on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_acks != hold_reqs) begin
      out_stall_i <= 1'b1;
      hold_acks   <= hold_acks + 1;
      hold_left   <= HoldLen - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct(cur_phase));
    end
  end

  // Monitor: every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (status_o <= STAT_NOTFOUND) status_tally[status_o]++;
      if (result_queue.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, got st %0d data %0d cnt %0d emp %0d",
                 $time, status_o, data_out_o, entry_count_o, is_empty_o);
      end else begin
        stack_result_t want;
        want = result_queue.pop_front();
        if (status_o !== want.status || data_out_o !== want.data ||
            entry_count_o !== want.count || is_empty_o !== want.empty) begin
          fail_count++;
          $display("%0t: mismatch, expected st %0d data %0d cnt %0d emp %0d,",
                   $time, want.status, want.data, want.count, want.empty);
          $display("%0t:   got st %0d data %0d cnt %0d emp %0d",
                   $time, status_o, data_out_o, entry_count_o, is_empty_o);
        end
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: watchdog, no transfer for %0d cycles", $time, IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Stimulus helpers -------------------------------------------------------

  task automatic add_op(input cmd_e op, input logic signed [WordW-1:0] arg, input int ph,
                        input bit wait_drain, input bit long_hold);
    stack_op_t o;
    o.op = op;
    o.arg = arg;
    o.phase = ph;
    o.wait_drain = wait_drain;
    o.long_hold = long_hold;
    op_queue.push_back(o);
  endtask

  // Small values repeat often so deletes find matches; full-range words
  // exercise every data bit.
  function automatic logic signed [WordW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 32'sh8000_0000;
      3:       return 32'sh7fff_ffff;
      4, 5, 6: return $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  // Runs of pushes to reach full, runs of pops/deletes to reach empty, and
  // mixed stretches in between.
  task automatic add_random(input int ph, input int n);
    int   added;
    int   run;
    int   roll;
    int   i;
    int   w;
    cmd_e op;
    added = 0;
    while (added < n) begin
      roll = $urandom_range(9);
      run  = (roll < 2) ? $urandom_range(18, 8) : (roll == 2) ? $urandom_range(16, 6) : 10;
      for (i = 0; i < run; i++) begin
        if (roll < 2) begin
          op = CMD_PUSH;
        end else if (roll == 2) begin
          op = ($urandom_range(3) == 0) ? CMD_DELETE : CMD_POP;
        end else begin
          w  = $urandom_range(99);
          op = (w < 35) ? CMD_PUSH : (w < 55) ? CMD_POP : (w < 70) ? CMD_PEEK : CMD_DELETE;
        end
        add_op(op, pick_value(), ph, 1'b0, 1'b0);
      end
      added += run;
    end
  endtask

  // Main sequence ----------------------------------------------------------

  initial begin
    int i;
    for (i = 0; i < 4; i++) begin
      op_tally[i] = 0;
      status_tally[i] = 0;
    end

    // Directed: empty stack corners, word extremes, top and bottom deletes,
    // delete miss, pop down to empty again.
    add_op(CMD_POP,    '0,              0, 1'b0, 1'b0);
    add_op(CMD_PEEK,   '0,              0, 1'b0, 1'b0);
    add_op(CMD_DELETE, 32'sd9,          0, 1'b0, 1'b0);
    add_op(CMD_PUSH,   32'sh8000_0000,  0, 1'b0, 1'b0);
    add_op(CMD_PUSH,   32'sh7fff_ffff,  0, 1'b0, 1'b0);
    add_op(CMD_PUSH,   '1,              0, 1'b0, 1'b0);
    add_op(CMD_PUSH,   '0,              0, 1'b0, 1'b0);
    add_op(CMD_PUSH,   32'sh7fff_ffff,  0, 1'b0, 1'b0);
    add_op(CMD_PEEK,   32'sh5555_aaaa,  0, 1'b0, 1'b0);
    add_op(CMD_DELETE, 32'sh7fff_ffff,  0, 1'b0, 1'b0);  // duplicate: top one goes
    add_op(CMD_DELETE, 32'sh8000_0000,  0, 1'b0, 1'b0);  // bottom entry
    add_op(CMD_DELETE, 32'sd12345,      0, 1'b0, 1'b0);  // miss
    add_op(CMD_POP,    '0,              0, 1'b0, 1'b0);
    add_op(CMD_POP,    '0,              0, 1'b0, 1'b0);
    add_op(CMD_POP,    '0,              0, 1'b0, 1'b0);
    add_op(CMD_DELETE, '1,              0, 1'b0, 1'b0);  // delete on empty
    add_op(CMD_POP,    '0,              0, 1'b0, 1'b0);

    add_random(0, 210);

    // Phase 1 starts only once the pipeline is drained.
    add_op(CMD_PEEK, pick_value(), 1, 1'b1, 1'b0);
    add_random(1, 210);

    // Phase 2: receiver holds off while pushes keep coming, so the stack
    // fills, refuses pushes and backs up into the input; then drain to empty.
    for (i = 0; i < 24; i++) add_op(CMD_PUSH, pick_value(), 2, i == 0, i == 0);
    for (i = 0; i < 20; i++) add_op(CMD_POP, pick_value(), 2, 1'b0, 1'b0);
    add_random(2, 160);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_queue.size() != 0 || in_valid_i || ops_taken != results_seen)
      @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);

    $display("Ran %0d commands: push %0d, pop %0d, peek %0d, delete %0d; deepest fill %0d of %0d.",
             ops_taken, op_tally[CMD_PUSH], op_tally[CMD_POP], op_tally[CMD_PEEK],
             op_tally[CMD_DELETE], deepest_fill, Depth);
    $display("Results by status: ok %0d, empty %0d, full %0d, not found %0d; %0d left unmatched.",
             status_tally[STAT_OK], status_tally[STAT_EMPTY], status_tally[STAT_FULL],
             status_tally[STAT_NOTFOUND], result_queue.size());
    if (result_queue.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
